>>> design/vcsr_pkg.sv
`default_nettype none
package vcsr_pkg;

	// Field widths of the command and result transactions.
	localparam int VEL_WIDTH        = 16;
	localparam int ANGLE_WIDTH      = 16;
	localparam int ROTATE_STEPS_DEF = 16;

	// Derived arithmetic widths.
	localparam int EXTRA_FRAC   = 8;
	localparam int ALPHA_W      = 16;
	localparam int FILT_W       = VEL_WIDTH + EXTRA_FRAC;
	localparam int ROT_W        = FILT_W + 3;
	localparam int ANG_ACC_W    = 32;
	localparam int ATAN_ENTRIES = 24;
	localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);
	localparam int GAIN_Q16     = 39797;
	localparam int GAIN_W       = 16;

	typedef struct packed {
		logic signed [VEL_WIDTH-1:0]   vel_x_in;
		logic signed [VEL_WIDTH-1:0]   vel_y_in;
		logic signed [VEL_WIDTH-1:0]   vel_z_in;
		logic signed [VEL_WIDTH-1:0]   yaw_rate_in;
		logic        [ANGLE_WIDTH-1:0] heading;
	} vcsr_in_t;

	typedef struct packed {
		logic signed [VEL_WIDTH-1:0] vel_x_out;
		logic signed [VEL_WIDTH-1:0] vel_y_out;
		logic signed [VEL_WIDTH-1:0] vel_z_out;
		logic signed [VEL_WIDTH-1:0] yaw_rate_out;
	} vcsr_out_t;

	// Filter lane control: mul launches the product, upd commits the store.
	typedef struct packed {
		logic mul;
		logic upd;
	} vcsr_filt_ctl_t;

	// Arctangent of 2^-i as a 32-bit binary angle.
	function automatic logic [ANG_ACC_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
		logic [ANG_ACC_W-1:0] v;
		case (idx)
			5'd0:    v = 32'd536870912;
			5'd1:    v = 32'd316933406;
			5'd2:    v = 32'd167458907;
			5'd3:    v = 32'd85004756;
			5'd4:    v = 32'd42667331;
			5'd5:    v = 32'd21354465;
			5'd6:    v = 32'd10679838;
			5'd7:    v = 32'd5340245;
			5'd8:    v = 32'd2670163;
			5'd9:    v = 32'd1335087;
			5'd10:   v = 32'd667544;
			5'd11:   v = 32'd333772;
			5'd12:   v = 32'd166886;
			5'd13:   v = 32'd83443;
			5'd14:   v = 32'd41722;
			5'd15:   v = 32'd20861;
			5'd16:   v = 32'd10430;
			5'd17:   v = 32'd5215;
			5'd18:   v = 32'd2608;
			5'd19:   v = 32'd1304;
			5'd20:   v = 32'd652;
			5'd21:   v = 32'd326;
			5'd22:   v = 32'd163;
			5'd23:   v = 32'd81;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

>>> design/vcsr_filter_lane.sv
`default_nettype none
module vcsr_filter_lane (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  vcsr_pkg::vcsr_filt_ctl_t             ctl,
	input  wire  [vcsr_pkg::ALPHA_W-1:0]         keep,
	input  wire  signed [vcsr_pkg::VEL_WIDTH-1:0] cmd,
	output logic signed [vcsr_pkg::FILT_W-1:0]   filt
);
	import vcsr_pkg::*;

	localparam int PROD_W = FILT_W + 1 + ALPHA_W + 1;
	localparam logic signed [PROD_W-1:0] ROUND_C = PROD_W'(2 ** (ALPHA_W - 1));

	logic signed [FILT_W-1:0] store_q;
	logic signed [FILT_W-1:0] cmd_sh;
	logic signed [FILT_W:0]   diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] rnd;

	// f*a + c*(1-a) is rewritten as (f - c)*a + c, so one multiplier serves.
	assign cmd_sh = {cmd, {EXTRA_FRAC{1'b0}}};
	assign diff   = (FILT_W + 1)'(store_q) - (FILT_W + 1)'(cmd_sh);
	assign prod   = PROD_W'(diff) * PROD_W'(signed'({1'b0, keep}));
	assign rnd    = (prod_s1 + ROUND_C) >>> ALPHA_W;

	always_ff @(posedge clk) begin
		if (ctl.mul) begin
			prod_s1 <= prod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
		end else if (ctl.upd) begin
			store_q <= rnd[FILT_W-1:0] + cmd_sh;
		end
	end

	assign filt = store_q;

endmodule
`default_nettype wire

>>> design/vcsr_rotate.sv
`default_nettype none
module vcsr_rotate #(
	parameter int ROTATE_STEPS = vcsr_pkg::ROTATE_STEPS_DEF
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    start,
	input  wire  signed [vcsr_pkg::FILT_W-1:0]     x0,
	input  wire  signed [vcsr_pkg::FILT_W-1:0]     y0,
	input  wire  [vcsr_pkg::ANGLE_WIDTH-1:0]       heading,
	output logic                                   done,
	output logic signed [vcsr_pkg::ROT_W-1:0]      x,
	output logic signed [vcsr_pkg::ROT_W-1:0]      y
);
	import vcsr_pkg::*;

	logic signed [ROT_W-1:0]     x_q;
	logic signed [ROT_W-1:0]     y_q;
	logic signed [ANG_ACC_W-1:0] z_q;
	logic [ATAN_IDX_W-1:0]       cnt_q;
	logic                        busy_q;
	logic                        done_q;

	logic [ANG_ACC_W-1:0]    ang;
	logic                    fold;
	logic signed [ROT_W-1:0] x_ext;
	logic signed [ROT_W-1:0] y_ext;
	logic signed [ROT_W-1:0] dx;
	logic signed [ROT_W-1:0] dy;
	logic [ANG_ACC_W-1:0]    atan_v;

	assign ang    = {heading, {(ANG_ACC_W - ANGLE_WIDTH){1'b0}}};
	// Angles in the second and third quadrants are folded by a half turn.
	assign fold   = ang[ANG_ACC_W-1] ^ ang[ANG_ACC_W-2];
	assign x_ext  = ROT_W'(x0);
	assign y_ext  = ROT_W'(y0);
	assign dx     = y_q >>> cnt_q;
	assign dy     = x_q >>> cnt_q;
	assign atan_v = atan_entry(cnt_q);

	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= fold ? -x_ext : x_ext;
			y_q <= fold ? -y_ext : y_ext;
			z_q <= signed'({ang[ANG_ACC_W-1] ^ fold, ang[ANG_ACC_W-2:0]});
		end else if (busy_q) begin
			if (!z_q[ANG_ACC_W-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - signed'(atan_v);
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + signed'(atan_v);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ATAN_IDX_W'(ROTATE_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign x    = x_q;
	assign y    = y_q;

endmodule
`default_nettype wire

>>> design/vcsr_merge.sv
`default_nettype none
module vcsr_merge (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	input  wire  signed [vcsr_pkg::ROT_W-1:0]    x,
	input  wire  signed [vcsr_pkg::ROT_W-1:0]    y,
	input  wire  signed [vcsr_pkg::FILT_W-1:0]   z_f,
	input  wire  signed [vcsr_pkg::FILT_W-1:0]   w_f,
	output logic                                 pend,
	output logic                                 res_valid,
	input  wire                                  res_ready,
	output vcsr_pkg::vcsr_out_t                  res
);
	import vcsr_pkg::*;

	localparam int GP_W       = ROT_W + GAIN_W + 1;
	localparam int GAIN_SHIFT = GAIN_W + EXTRA_FRAC;
	localparam logic signed [GP_W-1:0] GAIN_C  = GP_W'(GAIN_Q16);
	localparam logic signed [GP_W-1:0] GRND_C  = GP_W'(2 ** (GAIN_SHIFT - 1));
	localparam logic signed [GP_W-1:0] PRND_C  = GP_W'(2 ** (EXTRA_FRAC - 1));
	localparam logic signed [GP_W-1:0] VMAX_C  = GP_W'(2 ** (VEL_WIDTH - 1) - 1);
	localparam logic signed [GP_W-1:0] VMIN_C  = -VMAX_C - GP_W'(1);

	function automatic logic [VEL_WIDTH-1:0] sat(input logic signed [GP_W-1:0] v);
		logic signed [GP_W-1:0] c;
		c = v;
		if (v > VMAX_C) begin
			c = VMAX_C;
		end else if (v < VMIN_C) begin
			c = VMIN_C;
		end
		return c[VEL_WIDTH-1:0];
	endfunction

	logic signed [GP_W-1:0]   px_s1;
	logic signed [GP_W-1:0]   py_s1;
	logic signed [FILT_W-1:0] z_s1;
	logic signed [FILT_W-1:0] w_s1;
	logic                     v_s1;
	vcsr_out_t                res_q;
	logic                     res_valid_q;

	logic                   out_free;
	logic signed [GP_W-1:0] rx;
	logic signed [GP_W-1:0] ry;
	logic signed [GP_W-1:0] rz;
	logic signed [GP_W-1:0] rw;

	assign out_free = !res_valid_q || res_ready;
	assign rx = (px_s1 + GRND_C) >>> GAIN_SHIFT;
	assign ry = (py_s1 + GRND_C) >>> GAIN_SHIFT;
	assign rz = (GP_W'(z_s1) + PRND_C) >>> EXTRA_FRAC;
	assign rw = (GP_W'(w_s1) + PRND_C) >>> EXTRA_FRAC;

	always_ff @(posedge clk) begin
		if (start) begin
			px_s1 <= GP_W'(x) * GAIN_C;
			py_s1 <= GP_W'(y) * GAIN_C;
			z_s1  <= z_f;
			w_s1  <= w_f;
		end
		if (v_s1 && out_free) begin
			res_q.vel_x_out    <= sat(rx);
			res_q.vel_y_out    <= sat(ry);
			res_q.vel_z_out    <= sat(rz);
			res_q.yaw_rate_out <= sat(rw);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (start) begin
				v_s1 <= 1'b1;
			end else if (v_s1 && out_free) begin
				v_s1 <= 1'b0;
			end
			if (v_s1 && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	assign pend      = v_s1;
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule
`default_nettype wire

>>> design/velocity_command_smooth_rotate_top.sv
// Velocity command smoother with heading rotation.
//
// Channels: a command transaction (cmd_valid, cmd_ready, cmd) carries four
// Q8.8 velocity channels and a binary heading angle; a result transaction
// (res_valid, res_ready, res) carries the four output channels. A separate
// write channel (cfg_valid, cfg_ready, cfg_data) sets the smoothing factor
// alpha in Q0.16; it is always ready and should only be written while idle.
//
// Flow: only one command is in the filters and the rotator at a time, and a
// new command is not taken until the previous result has left the gain
// stage; the iterative shift-and-add rotator performs one step per cycle.
//
// Reset clears the four filter stores and alpha to zero, so the filter
// starts as a pass-through. When the receiver stalls, the finished result
// waits in the output register while the next command is still accepted
// and processed; it then waits in the gain stage until the output frees.
`default_nettype none
module velocity_command_smooth_rotate_top #(
	parameter int ROTATE_STEPS = vcsr_pkg::ROTATE_STEPS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cmd_valid,
	output logic                         cmd_ready,
	input  vcsr_pkg::vcsr_in_t           cmd,
	output logic                         res_valid,
	input  wire                          res_ready,
	output vcsr_pkg::vcsr_out_t          res,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [vcsr_pkg::ALPHA_W-1:0] cfg_data
);
	import vcsr_pkg::*;

	// Sequencer states.
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_LOAD = 3'd3;
	localparam logic [2:0] ST_ROT  = 3'd4;

	logic [2:0]         state_q;
	logic [ALPHA_W-1:0] keep_q;
	vcsr_in_t           cmd_q;

	vcsr_filt_ctl_t           filt_ctl;
	logic signed [FILT_W-1:0] f_x;
	logic signed [FILT_W-1:0] f_y;
	logic signed [FILT_W-1:0] f_z;
	logic signed [FILT_W-1:0] f_w;
	logic                     rot_start;
	logic                     rot_done;
	logic signed [ROT_W-1:0]  rot_x;
	logic signed [ROT_W-1:0]  rot_y;
	logic                     merge_pend;
	logic                     cmd_fire;

	// A new command is taken only when the sequencer is free and the gain
	// stage has no result of its own still waiting for the output register.
	assign cmd_ready = (state_q == ST_IDLE) && !merge_pend;
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= '0;
		end else if (cfg_valid) begin
			keep_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_fire) begin
			cmd_q <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (cmd_fire) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_UPD;
				ST_UPD:  state_q <= ST_LOAD;
				ST_LOAD: state_q <= ST_ROT;
				ST_ROT:  if (rot_done) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The products are registered in the multiply state and the stores updated
	// in the update state; the rotator loads the freshly updated x and y stores after that.
	assign filt_ctl.mul = (state_q == ST_MUL);
	assign filt_ctl.upd = (state_q == ST_UPD);
	assign rot_start    = (state_q == ST_LOAD);

	vcsr_filter_lane u_lane_x (
		.clk(clk), .arst_n(arst_n), .ctl(filt_ctl), .keep(keep_q),
		.cmd(cmd_q.vel_x_in), .filt(f_x)
	);

	vcsr_filter_lane u_lane_y (
		.clk(clk), .arst_n(arst_n), .ctl(filt_ctl), .keep(keep_q),
		.cmd(cmd_q.vel_y_in), .filt(f_y)
	);

	vcsr_filter_lane u_lane_z (
		.clk(clk), .arst_n(arst_n), .ctl(filt_ctl), .keep(keep_q),
		.cmd(cmd_q.vel_z_in), .filt(f_z)
	);

	vcsr_filter_lane u_lane_w (
		.clk(clk), .arst_n(arst_n), .ctl(filt_ctl), .keep(keep_q),
		.cmd(cmd_q.yaw_rate_in), .filt(f_w)
	);

	vcsr_rotate #(
		.ROTATE_STEPS(ROTATE_STEPS)
	) u_rotate (
		.clk(clk), .arst_n(arst_n), .start(rot_start),
		.x0(f_x), .y0(f_y), .heading(cmd_q.heading),
		.done(rot_done), .x(rot_x), .y(rot_y)
	);

	// The merging stage applies the rotator gain to x and y, rounds the two
	// pass-through channels and holds the combined result for the receiver.
	vcsr_merge u_merge (
		.clk(clk), .arst_n(arst_n), .start(rot_done),
		.x(rot_x), .y(rot_y), .z_f(f_z), .w_f(f_w),
		.pend(merge_pend), .res_valid(res_valid), .res_ready(res_ready), .res(res)
	);

	// The rotator finishes only while the sequencer waits for it.
	a_done_in_rot: assert property (@(posedge clk) disable iff (!arst_n)
		rot_done |-> (state_q == ST_ROT))
		else $error("rotator finished outside the rotate state");

	// A finishing rotation never overwrites a result still held in the gain stage.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		rot_done |-> !merge_pend)
		else $error("gain stage overwritten while occupied");

	// The store update always follows the multiply cycle.
	a_mul_then_upd: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |=> (state_q == ST_UPD))
		else $error("filter update did not follow multiply");

	// A command transaction leads to the multiply cycle.
	a_fire_then_mul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire |=> filt_ctl.mul)
		else $error("accepted command did not start filtering");

endmodule
`default_nettype wire
